// ----- sv/crn_pkg.sv -----
// ----------------------------------------------------------------------------
// crn_pkg
// shared types, register defaults and result saturation for the
// cross-channel response normalizer
// ----------------------------------------------------------------------------
package crn_pkg;

    // fixed data format: signed q8.8 activations
    localparam int DataW = 16;
    localparam int CountW = 11;
    localparam int BiasW = 16;
    localparam int AlphaW = 24;
    localparam int CfgW = 24;
    localparam int CfgIdxW = 2;

    localparam int DefWindowSize = 5;
    localparam int DefMaxChannels = 1024;
    localparam int QueueDepth = 4;

    localparam logic [CountW-1:0] ResetChannelCount = 11'd64;
    localparam logic [BiasW-1:0] ResetBiasK = 16'd512;
    localparam logic [AlphaW-1:0] ResetAlphaGain = 24'd6711;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_BIAS_K = 2'd1,
        REG_ALPHA_GAIN = 2'd2,
        REG_UNUSED = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // saturate a magnitude to q8.8 and apply the sign
    function automatic logic [DataW-1:0] sat_q(input logic neg, input logic [63:0] q);
        logic [63:0] qq;
        begin
            if (neg) begin
                qq = (q > 64'd32768) ? 64'd32768 : q;
                sat_q = 16'(64'd0 - qq);
            end else begin
                qq = (q > 64'd32767) ? 64'd32767 : q;
                sat_q = 16'(qq);
            end
        end
    endfunction

endpackage

// ----- sv/crn_queue.sv -----
// ----------------------------------------------------------------------------
// crn_queue
// small job queue between the classifying front end and the arithmetic back end
// ----------------------------------------------------------------------------
module crn_queue #(
    parameter int WIDTH = 52
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output crn_pkg::t_q_status o_status
);
    import crn_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    logic [WIDTH-1:0] r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [PtrW:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == (PtrW+1)'(QueueDepth));
    assign o_status.empty = (r_cnt == '0);

endmodule

// ----- sv/crn_front.sv -----
// ----------------------------------------------------------------------------
// crn_front
// accepts activations, keeps the channel window and issues one job per
// channel that becomes due
// ----------------------------------------------------------------------------
module crn_front #(
    parameter int WINDOW_SIZE  = 5,
    parameter int MAX_CHANNELS = 1024,
    parameter int S_W          = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [crn_pkg::DataW-1:0] i_activation,
    input  logic [crn_pkg::CountW-1:0]    i_channel_count,
    input  crn_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output logic signed [crn_pkg::DataW-1:0] o_job_x,
    output logic [S_W-1:0]                o_job_s,
    output logic                          o_job_last
);
    import crn_pkg::*;

    localparam int Half = WINDOW_SIZE / 2;
    localparam int Span = 2 * Half + 1;
    localparam int AgeW = (Span > 1) ? $clog2(Span) : 1;
    localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CmpW = ($clog2(MAX_CHANNELS + 1) > CountW) ?
                          $clog2(MAX_CHANNELS + 1) : CountW;
    localparam int SqW = 2 * DataW - 1;

    typedef enum logic {F_IDLE, F_GEN} t_fstate;

    t_fstate                 r_state;
    logic [IdxW-1:0]         r_idx;
    logic [IdxW-1:0]         r_c;
    logic                    r_last;
    logic [AgeW-1:0]         r_d;
    logic [AgeW-1:0]         r_dend;
    logic signed [DataW-1:0] r_win [Span];
    logic [SqW-1:0]          r_sq [Span];

    logic [CmpW-1:0]         cnt_eff;
    logic [CmpW-1:0]         cc_ext;
    logic                    is_last;
    logic                    accept;
    logic [S_W-1:0]          sum;
    logic signed [2*DataW-1:0] sq_full;

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;
    assign sq_full = i_activation * i_activation;

    // effective channel count, zero read as one, clamped to the maximum
    always_comb begin
        cc_ext = CmpW'(i_channel_count);
        priority if (cc_ext == '0) begin
            cnt_eff = CmpW'(1);
        end else if (cc_ext > CmpW'(MAX_CHANNELS)) begin
            cnt_eff = CmpW'(MAX_CHANNELS);
        end else begin
            cnt_eff = cc_ext;
        end
        is_last = (CmpW'(r_idx) >= cnt_eff - 1'b1);
    end

    // windowed sum of squares for the channel at age r_d
    always_comb begin
        int d;
        d   = int'(r_d);
        sum = '0;
        for (int a = 0; a < Span; a++) begin
            if ((a + Half >= d) && (a <= d + Half) && (a <= int'(r_c))) begin
                sum = sum + S_W'(r_sq[a]);
            end
        end
    end

    assign o_push     = (r_state == F_GEN) && !i_q_status.full;
    assign o_job_x    = r_win[r_d];
    assign o_job_s    = sum;
    assign o_job_last = r_last && (r_d == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= '0;
            r_c     <= '0;
            r_last  <= 1'b0;
            r_d     <= '0;
            r_dend  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_c    <= r_idx;
                        r_last <= is_last;
                        r_idx  <= is_last ? '0 : r_idx + 1'b1;
                        if (is_last) begin
                            r_d     <= (int'(r_idx) >= Half) ? AgeW'(Half) : AgeW'(r_idx);
                            r_dend  <= '0;
                            r_state <= F_GEN;
                        end else if (int'(r_idx) >= Half) begin
                            r_d     <= AgeW'(Half);
                            r_dend  <= AgeW'(Half);
                            r_state <= F_GEN;
                        end
                    end
                end
                F_GEN: begin
                    if (o_push) begin
                        if (r_d == r_dend) begin
                            r_state <= F_IDLE;
                        end else begin
                            r_d <= r_d - 1'b1;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // window of values and their squares, newest at age zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= i_activation;
            r_sq[0]  <= SqW'(sq_full);
            for (int k = 1; k < Span; k++) begin
                r_win[k] <= r_win[k-1];
                r_sq[k]  <= r_sq[k-1];
            end
        end
    end

endmodule

// ----- sv/crn_back.sv -----
// ----------------------------------------------------------------------------
// crn_back
// per-job arithmetic: denominator, normalize, two square roots, rounding
// divide and saturation, with a registered result stage
// ----------------------------------------------------------------------------
module crn_back #(
    parameter int S_W = 34
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crn_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    input  logic signed [crn_pkg::DataW-1:0] i_job_x,
    input  logic [S_W-1:0]                i_job_s,
    input  logic                          i_job_last,
    input  logic [crn_pkg::BiasW-1:0]     i_bias_k,
    input  logic [crn_pkg::AlphaW-1:0]    i_alpha_gain,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [crn_pkg::DataW-1:0] o_normalized,
    output logic                          o_pixel_last
);
    import crn_pkg::*;

    localparam int VW = S_W + 25;
    localparam int LoW = (S_W + 1) / 2;
    localparam int HiW = S_W - LoW;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL0, B_MUL1, B_NORM, B_SQ1, B_PROD0, B_PROD1,
        B_SQ2, B_DIVSET, B_DIV, B_OUT
    } t_bstate;

    t_bstate                 r_state;
    logic signed [DataW-1:0] r_x;
    logic [S_W-1:0]          r_s;
    logic                    r_last;
    logic [VW-1:0]           r_v;
    logic [VW-1:0]           r_m;
    logic signed [4:0]       r_e;
    logic [19:0]             r_r1;
    logic [59:0]             r_prod;
    logic [29:0]             r_p;
    logic [59:0]             r_sq_op;
    logic [31:0]             r_sq_rem;
    logic [29:0]             r_sq_root;
    logic [6:0]              r_cnt;
    logic [63:0]             r_num;
    logic [30:0]             r_rem;
    logic [63:0]             r_q;
    logic [DataW-1:0]        r_res;
    logic                    r_out_valid;
    logic signed [DataW-1:0] r_out_norm;
    logic                    r_out_last;

    logic                    neg;
    logic [DataW-1:0]        mag;
    logic [33:0]             sq_cat;
    logic [33:0]             sq_trial;
    logic                    sq_ge;
    logic [33:0]             sq_diff;
    logic [31:0]             d_cat;
    logic                    d_ge;
    logic [31:0]             d_diff;
    logic                    out_free;
    logic                    out_load;
    int                      t_sh;

    assign neg = r_x[DataW-1];
    assign mag = neg ? DataW'(-r_x) : DataW'(r_x);

    // one restoring square-root step, two operand bits per cycle
    assign sq_cat   = {r_sq_rem, r_sq_op[59:58]};
    assign sq_trial = {2'b00, r_sq_root, 2'b01};
    assign sq_ge    = (sq_cat >= sq_trial);
    assign sq_diff  = sq_cat - sq_trial;

    // one restoring division step
    assign d_cat  = {r_rem, r_num[63]};
    assign d_ge   = (d_cat >= {2'b00, r_p});
    assign d_diff = d_cat - {2'b00, r_p};

    assign t_sh     = 30 - 3 * int'(r_e);
    assign out_free = !r_out_valid || i_ready;
    assign out_load = (r_state == B_OUT) && out_free;
    assign o_pop    = (r_state == B_IDLE) && !i_q_status.empty;

    assign o_valid      = r_out_valid;
    assign o_normalized = r_out_norm;
    assign o_pixel_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_x     <= i_job_x;
                        r_s     <= i_job_s;
                        r_last  <= i_job_last;
                        r_state <= B_MUL0;
                    end
                end
                B_MUL0: begin
                    r_v <= VW'({i_bias_k, 32'd0}) + VW'(i_alpha_gain * r_s[LoW-1:0]);
                    r_state <= B_MUL1;
                end
                B_MUL1: begin
                    r_v <= r_v + (VW'(i_alpha_gain * r_s[S_W-1 -: HiW]) << LoW);
                    r_m <= r_v + (VW'(i_alpha_gain * r_s[S_W-1 -: HiW]) << LoW);
                    r_e <= '0;
                    r_state <= B_NORM;
                end
                B_NORM: begin
                    priority if (mag == '0) begin
                        r_res   <= '0;
                        r_state <= B_OUT;
                    end else if (r_v == '0) begin
                        r_res   <= sat_q(neg, 64'd32769);
                        r_state <= B_OUT;
                    end else if (r_m >= (VW'(1) << 40)) begin
                        r_m <= r_m >> 4;
                        r_e <= r_e + 5'sd1;
                    end else if (r_m < (VW'(1) << 36)) begin
                        r_m <= r_m << 4;
                        r_e <= r_e - 5'sd1;
                    end else begin
                        r_sq_op   <= {20'd0, r_m[39:0]};
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                        r_cnt     <= '0;
                        r_state   <= B_SQ1;
                    end
                end
                B_SQ1, B_SQ2: begin
                    r_sq_op   <= r_sq_op << 2;
                    r_sq_rem  <= sq_ge ? sq_diff[31:0] : sq_cat[31:0];
                    r_sq_root <= {r_sq_root[28:0], sq_ge};
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == 7'd29) begin
                        if (r_state == B_SQ1) begin
                            r_r1    <= {r_sq_root[18:0], sq_ge};
                            r_state <= B_PROD0;
                        end else begin
                            r_p     <= {r_sq_root[28:0], sq_ge};
                            r_state <= B_DIVSET;
                        end
                    end
                end
                B_PROD0: begin
                    r_prod  <= 60'(r_m[19:0] * r_r1);
                    r_state <= B_PROD1;
                end
                B_PROD1: begin
                    r_sq_op   <= r_prod + (60'(r_m[39:20] * r_r1) << 20);
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= '0;
                    r_state   <= B_SQ2;
                end
                B_DIVSET: begin
                    if (t_sh > 47) begin
                        r_res   <= sat_q(neg, 64'd32769);
                        r_state <= B_OUT;
                    end else begin
                        r_num   <= (64'(mag) << t_sh[5:0]) + 64'(r_p >> 1);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_num <= r_num << 1;
                    r_rem <= d_ge ? d_diff[30:0] : d_cat[30:0];
                    r_q   <= {r_q[62:0], d_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd63) begin
                        r_res   <= sat_q(neg, {r_q[62:0], d_ge});
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out_norm  <= r_res;
                        r_out_last  <= r_last;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/cross_channel_response_norm.sv -----
// ----------------------------------------------------------------------------
// cross_channel_response_norm
// streaming cross-channel local response normalization on q8.8 activations
// ----------------------------------------------------------------------------
// Activations enter one per item in channel-innermost order. Each normalized
// result is x * (k + alpha * S)^(-3/4), with S the sum of squares over the
// neighboring channels of the same pixel, rounded and saturated to q8.8.
// Results lag the input by WINDOW_SIZE/2 channels; the last channel of a
// pixel releases all pending channels, the final one marked with pixel_last.
// Flow: the front end accepts an item while idle; an item that yields jobs
// (up to WINDOW_SIZE/2+1 jobs on the last channel) holds it busy, issuing
// one job per cycle while the queue has room. The back end works on one
// job at a time, through the normalizing shifts (up to 9), the two iterative
// square roots (30 steps each) and the 64-step rounding divide; a zero
// activation skips the shifts, roots and divide. A four-entry job queue lets
// the front end run ahead of the back end.
module cross_channel_response_norm #(
    parameter int WINDOW_SIZE  = crn_pkg::DefWindowSize,
    parameter int MAX_CHANNELS = crn_pkg::DefMaxChannels
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [crn_pkg::DataW-1:0]  i_activation,
    // result items
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [crn_pkg::DataW-1:0]  o_normalized,
    output logic                              o_pixel_last,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [crn_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [crn_pkg::CfgW-1:0]          i_cfg_data
);
    import crn_pkg::*;

    localparam int Span = 2 * (WINDOW_SIZE / 2) + 1;
    // sum of squares width: one square is at most 2^30
    localparam int S_W = 31 + $clog2(Span);
    localparam int JobW = DataW + S_W + 1;

    logic [CountW-1:0] r_channel_count;
    logic [BiasW-1:0]  r_bias_k;
    logic [AlphaW-1:0] r_alpha_gain;

    logic                    q_push;
    logic                    q_pop;
    t_q_status               q_stat;
    logic signed [DataW-1:0] f_x;
    logic [S_W-1:0]          f_s;
    logic                    f_last;
    logic [JobW-1:0]         q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= ResetChannelCount;
            r_bias_k        <= ResetBiasK;
            r_alpha_gain    <= ResetAlphaGain;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CountW-1:0];
                REG_BIAS_K:        r_bias_k        <= i_cfg_data[BiasW-1:0];
                REG_ALPHA_GAIN:    r_alpha_gain    <= i_cfg_data[AlphaW-1:0];
                REG_UNUSED:        ;
                default:           ;
            endcase
        end
    end

    // front end: window, channel count, job issue
    crn_front #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .MAX_CHANNELS (MAX_CHANNELS),
        .S_W          (S_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_activation    (i_activation),
        .i_channel_count (r_channel_count),
        .i_q_status      (q_stat),
        .o_push          (q_push),
        .o_job_x         (f_x),
        .o_job_s         (f_s),
        .o_job_last      (f_last)
    );

    // job queue between the two halves
    crn_queue #(
        .WIDTH (JobW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   ({f_x, f_s, f_last}),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_stat)
    );

    // back end: arithmetic and result register
    crn_back #(
        .S_W (S_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_stat),
        .o_pop        (q_pop),
        .i_job_x      (q_out[JobW-1 -: DataW]),
        .i_job_s      (q_out[S_W:1]),
        .i_job_last   (q_out[0]),
        .i_bias_k     (r_bias_k),
        .i_alpha_gain (r_alpha_gain),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_normalized (o_normalized),
        .o_pixel_last (o_pixel_last)
    );

    // no job pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("job pushed into full queue");

    // no job popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("job popped from empty queue");

    // a push without a pop leaves the queue non-empty
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("pushed job lost");

endmodule

// ----- tb/tb_cross_channel_response_norm.sv -----
// ----------------------------------------------------------------------------
// tb_cross_channel_response_norm
// self-checking bench for the cross-channel response normalizer
// ----------------------------------------------------------------------------
// A queue of activations feeds a clocked driver; a clocked monitor checks each
// result item against an expectation computed by an in-bench fixed-point
// model of the normalizer. Directed items cover the extremes, the zero
// denominator, the oversized quotient, channel count clamping and a count
// lowered mid-pixel. Random phases follow with random settings, random idling
// on both sides and one pause until all pending results have drained.
// ----------------------------------------------------------------------------
module tb_cross_channel_response_norm;
    import crn_pkg::*;

    localparam int HalfWin = DefWindowSize / 2;
    localparam int WinSpan = 2 * HalfWin + 1;
    localparam int DrainCycles = 800;
    localparam int StuckLimit = 6000;

    typedef struct {
        logic [DataW-1:0] normalized;
        logic             pixel_last;
    } t_norm_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [DataW-1:0] i_activation;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [DataW-1:0] o_normalized;
    logic                    o_pixel_last;
    logic                    i_cfg_we;
    logic [CfgIdxW-1:0]      i_cfg_index;
    logic [CfgW-1:0]         i_cfg_data;

    // shadow of the block's registers and stream state
    logic [CountW-1:0]       shadow_count;
    logic [BiasW-1:0]        shadow_bias;
    logic [AlphaW-1:0]       shadow_alpha;
    logic signed [DataW-1:0] recent_vals[WinSpan];
    int                      chan_pos;

    logic signed [DataW-1:0] act_queue[$];
    t_norm_result            result_queue[$];

    int  error_count = 0;
    int  send_gap;
    int  recv_stall;
    bit  send_idling;
    bit  recv_idling;
    int  stuck_cycles;

    cross_channel_response_norm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_activation(i_activation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_normalized(o_normalized),
        .o_pixel_last(o_pixel_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // clip a magnitude to q8.8 and give it the sign
    function automatic logic [DataW-1:0] clip_signed(input bit neg, input longint unsigned q);
        begin
            if (neg) begin
                if (q > 64'd32768) q = 64'd32768;
                return DataW'(64'd0 - q);
            end
            return DataW'((q > 64'd32767) ? 64'd32767 : q);
        end
    endfunction

    // x * v^(-3/4) with v in unsigned q.40
    function automatic logic [DataW-1:0] lrn_scale(input logic signed [DataW-1:0] x,
                                                   input longint unsigned v);
        bit              neg;
        longint unsigned mag;
        longint unsigned m;
        longint unsigned p;
        int              e;
        int              t;
        begin
            neg = x < 0;
            mag = neg ? longint'(-int'(x)) : longint'(int'(x));
            if (mag == 0) return '0;
            if (v == 0) return clip_signed(neg, 64'd32769);
            m = v;
            e = 0;
            while (m >= (64'd1 << 40)) begin
                m = m >> 4;
                e++;
            end
            while (m < (64'd1 << 36)) begin
                m = m << 4;
                e--;
            end
            p = floor_sqrt(m * floor_sqrt(m));
            t = 30 - 3 * e;
            if (t > 47) return clip_signed(neg, 64'd32769);
            return clip_signed(neg, ((mag << t) + (p >> 1)) / p);
        end
    endfunction

    // shift one accepted activation in and queue the results it releases
    task automatic predict_activation(input logic signed [DataW-1:0] act);
        int              cnt;
        int              c;
        int              j_first;
        int              j_last;
        int              lo;
        int              hi;
        bit              last;
        longint          w;
        longint unsigned sq_sum;
        longint unsigned denom;
        t_norm_result    r;
        begin
            cnt = int'(shadow_count);
            if (cnt == 0) cnt = 1;
            if (cnt > DefMaxChannels) cnt = DefMaxChannels;
            c = chan_pos;
            last = c >= cnt - 1;
            for (int k = WinSpan - 1; k > 0; k--) recent_vals[k] = recent_vals[k-1];
            recent_vals[0] = act;
            // a pixel end flushes every channel still waiting for its right side
            if (last) begin
                j_first = (c >= HalfWin) ? c - HalfWin : 0;
                j_last = c;
            end else if (c >= HalfWin) begin
                j_first = c - HalfWin;
                j_last = j_first;
            end else begin
                j_first = 1;
                j_last = 0;
            end
            for (int j = j_first; j <= j_last; j++) begin
                // window clamped to the current pixel on both sides
                lo = (j >= HalfWin) ? j - HalfWin : 0;
                hi = (j + HalfWin < c) ? j + HalfWin : c;
                sq_sum = 0;
                for (int i = lo; i <= hi; i++) begin
                    w = recent_vals[(c - i) % WinSpan];
                    sq_sum += longint'(w * w);
                end
                denom = (longint'(shadow_bias) << 32) + longint'(shadow_alpha) * sq_sum;
                r.normalized = lrn_scale(recent_vals[(c - j) % WinSpan], denom);
                r.pixel_last = last && (j == c);
                result_queue.push_back(r);
            end
            chan_pos = last ? 0 : c + 1;
        end
    endtask

    // driver: one item on the input channel, random gap after each item when idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_activation <= '0;
            send_gap <= 0;
            foreach (recent_vals[k]) recent_vals[k] = '0;
            chan_pos = 0;
        end else begin
            if (i_valid && o_ready) predict_activation(i_activation);
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (act_queue.size() > 0) begin
                    i_valid <= 1'b1;
                    i_activation <= act_queue.pop_front();
                    send_gap <= send_idling ? $urandom_range(0, 12) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result item, random stall after each item when idling
    always @(posedge i_clk) begin
        t_norm_result want;
        int           stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall <= 0;
        end else if (o_valid && i_ready) begin
            if (result_queue.size() == 0) begin
                $error("unexpected result item: normalized %0d pixel_last %0b",
                       o_normalized, o_pixel_last);
                error_count++;
            end else begin
                want = result_queue.pop_front();
                if (o_normalized !== want.normalized) begin
                    $error("normalized: expected %0d, got %0d",
                           $signed(want.normalized), o_normalized);
                    error_count++;
                end
                if (o_pixel_last !== want.pixel_last) begin
                    $error("pixel_last: expected %0b, got %0b", want.pixel_last, o_pixel_last);
                    error_count++;
                end
            end
            stall = recv_idling ? $urandom_range(0, 12) : 0;
            recv_stall <= stall;
            i_ready <= (stall == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            i_ready <= (recv_stall == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog: cycles with work outstanding but no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (i_valid || act_queue.size() > 0 || result_queue.size() > 0) begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= StuckLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CfgW-1:0] data);
        begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= data;
            case (idx)
                REG_CHANNEL_COUNT: shadow_count = data[CountW-1:0];
                REG_BIAS_K: shadow_bias = data[BiasW-1:0];
                REG_ALPHA_GAIN: shadow_alpha = data[AlphaW-1:0];
                default: ;
            endcase
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic set_config(input int cnt, input int bias, input int alpha);
        begin
            write_reg(REG_CHANNEL_COUNT, CfgW'(cnt));
            write_reg(REG_BIAS_K, CfgW'(bias));
            write_reg(REG_ALPHA_GAIN, CfgW'(alpha));
        end
    endtask

    // everything sent and answered, then let the back end settle
    task automatic wait_drained();
        begin
            while (act_queue.size() > 0 || i_valid || result_queue.size() > 0)
                @(posedge i_clk);
            repeat (DrainCycles) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DataW-1:0] random_act();
        case ($urandom_range(0, 3))
            0: return DataW'($urandom);
            1: return DataW'($signed($urandom_range(0, 1024)) - 512);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return DataW'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    initial begin
        int n_items;
        int cnt;
        int bias;
        int alpha;
        shadow_count = ResetChannelCount;
        shadow_bias = ResetBiasK;
        shadow_alpha = ResetAlphaGain;
        send_idling = 1'b0;
        recv_idling = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few items at the reset settings
        act_queue = '{16'sd256, -16'sd300, 16'sd1000};
        wait_drained();

        // extremes of the activation over two pixels of four channels
        set_config(4, 512, 6711);
        write_reg(REG_UNUSED, '1);
        act_queue = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1,
                      -16'sd1, 16'sd256, -16'sd256, 16'sh5a5a};
        wait_drained();

        // zero denominator: no bias and no gain, one channel per pixel
        set_config(1, 0, 0);
        act_queue = '{16'sd5, -16'sd5, 16'sd0};
        wait_drained();

        // quotient too large for the shift: tiny denominator
        set_config(2, 0, 1);
        act_queue = '{16'sd1, -16'sd1};
        wait_drained();

        // channel count of zero behaves as one; largest bias and gain
        set_config(0, 65535, 16777215);
        act_queue = '{16'sh7fff, 16'sh8000};
        wait_drained();

        // count lowered in the middle of a pixel
        set_config(8, 512, 6711);
        act_queue = '{16'sd100, -16'sd200, 16'sd300, -16'sd400, 16'sd500};
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 3);
        act_queue = '{16'sd600, 16'sd700};
        wait_drained();

        // count above the maximum is clamped
        write_reg(REG_CHANNEL_COUNT, 2047);
        act_queue = '{16'sd50, -16'sd60, 16'sd70};
        wait_drained();

        // random phases
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 4))
                0: cnt = 1;
                1: cnt = $urandom_range(2, 5);
                2: cnt = $urandom_range(6, 12);
                3: cnt = $urandom_range(13, 40);
                default: cnt = (phase == 6) ? 1024 : $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0: bias = 1;
                1: bias = 65535;
                default: bias = $urandom_range(1, 65535);
            endcase
            case ($urandom_range(0, 3))
                0: alpha = 0;
                1: alpha = 24'hffffff;
                2: alpha = $urandom_range(0, 20000);
                default: alpha = $urandom & 24'hffffff;
            endcase
            set_config(cnt, bias, alpha);
            send_idling = (phase % 3) != 0;
            recv_idling = (phase % 2) != 0;
            n_items = 15;
            for (int i = 0; i < ((phase == 2) ? n_items / 2 : n_items); i++)
                act_queue.push_back(random_act());
            // hold the sender until all pending results have drained
            if (phase == 2) begin
                while (act_queue.size() > 0 || i_valid || result_queue.size() > 0)
                    @(posedge i_clk);
                for (int i = n_items / 2; i < n_items; i++) act_queue.push_back(random_act());
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
